// File: hdl/rrc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrc_pkg
// shared types and constants for the request result cache
// ----------------------------------------------------------------------------
package rrc_pkg;

  localparam int unsigned NUM_ENTRIES_DEF = 8;
  localparam int unsigned TTL_RESET       = 1000;

  localparam int unsigned KEY_W   = 56;
  localparam int unsigned PAY_W   = 40;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned IN_W    = 136;
  localparam int unsigned OUT_W   = 32;

  // request kinds
  localparam logic MODE_FIND  = 1'b0;
  localparam logic MODE_STORE = 1'b1;

  typedef enum logic [1:0] {
    OUT_MISS     = 2'd0,
    OUT_FOUND    = 2'd1,
    OUT_CONFLICT = 2'd2,
    OUT_STORED   = 2'd3
  } outcome_t;

  // write controls towards the entry store
  typedef struct packed {
    logic ent_we;
    logic touch_we;
    logic set_valid;
    logic clr_valid;
  } rrc_wr_t;

  // results of the shared compare unit
  typedef struct packed {
    logic age_exp;
    logic key_eq;
    logic attr_eq;
    logic older;
  } rrc_cmp_t;

endpackage : rrc_pkg
`default_nettype wire

// File: hdl/rrc_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrc_mem
// entry store: valid flags in flops, key, payload and touch time in memories
// ----------------------------------------------------------------------------
module rrc_mem
  import rrc_pkg::*;
#(
  parameter int unsigned NUM_ENTRIES = NUM_ENTRIES_DEF,
  parameter int unsigned AW          = 3
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    rd_en,
  input  wire logic [AW-1:0]           rd_addr,
  output logic      [KEY_W-1:0]        rd_key,
  output logic      [PAY_W-1:0]        rd_pay,
  output logic      [TIME_W-1:0]       rd_touch,
  input  wire rrc_wr_t                 wr_ctl,
  input  wire logic [AW-1:0]           wr_addr,
  input  wire logic [KEY_W-1:0]        wr_key,
  input  wire logic [PAY_W-1:0]        wr_pay,
  input  wire logic [TIME_W-1:0]       wr_touch,
  output logic      [NUM_ENTRIES-1:0]  valid_vec
);

  logic [KEY_W-1:0]       key_mem   [NUM_ENTRIES];
  logic [PAY_W-1:0]       pay_mem   [NUM_ENTRIES];
  logic [TIME_W-1:0]      touch_mem [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (wr_ctl.ent_we) begin
      key_mem[wr_addr] <= wr_key;
      pay_mem[wr_addr] <= wr_pay;
    end
    if (wr_ctl.touch_we) begin
      touch_mem[wr_addr] <= wr_touch;
    end
    if (rd_en) begin
      rd_key   <= key_mem[rd_addr];
      rd_pay   <= pay_mem[rd_addr];
      rd_touch <= touch_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_ctl.set_valid) begin
      valid_r[wr_addr] <= 1'b1;
    end else if (wr_ctl.clr_valid) begin
      valid_r[wr_addr] <= 1'b0;
    end
  end

  assign valid_vec = valid_r;

endmodule : rrc_mem
`default_nettype wire

// File: hdl/rrc_cmp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrc_cmp
// shared compare unit: age against ttl, key and attribute match, wrap-aware age order
// ----------------------------------------------------------------------------
module rrc_cmp
  import rrc_pkg::*;
(
  input  wire logic [TIME_W-1:0] now_time,
  input  wire logic [TIME_W-1:0] ttl,
  input  wire logic [TIME_W-1:0] ent_touch,
  input  wire logic [TIME_W-1:0] tgt_touch,
  input  wire logic [KEY_W-1:0]  req_key,
  input  wire logic [KEY_W-1:0]  ent_key,
  input  wire logic [7:0]        req_svc,
  input  wire logic [7:0]        req_opc,
  input  wire logic [PAY_W-1:0]  ent_pay,
  output rrc_cmp_t               res
);

  logic [TIME_W-1:0] age;
  logic [TIME_W-1:0] diff;

  always_comb begin
    age          = now_time - ent_touch;
    diff         = ent_touch - tgt_touch;
    res.age_exp  = (age >= ttl);
    res.key_eq   = (ent_key == req_key);
    res.attr_eq  = (ent_pay[39:32] == req_svc) && (ent_pay[31:24] == req_opc);
    // touched earlier than the current candidate, modulo wrap
    res.older    = diff[TIME_W-1];
  end

endmodule : rrc_cmp
`default_nettype wire

// File: hdl/request_result_cache_ttl_lru.sv
`default_nettype none
// ----------------------------------------------------------------------------
// request_result_cache_ttl_lru
// cache of request results with time-to-live expiry and least-recently-touched
// replacement, scanned one entry a cycle through one compare unit
// ----------------------------------------------------------------------------
// a find or store ends its scan at the entry that settles it; a miss or a
//   replacing store scans every entry
// throughput: one word at a time; the scan reads one entry a cycle from the
//   single read port of the entry store
// the input is taken again while a finished result waits in the output register
// reset: valid flags cleared at once, ttl set to 1000, no clearing pass
// ----------------------------------------------------------------------------
module request_result_cache_ttl_lru
  import rrc_pkg::*;
#(
  parameter int unsigned NUM_ENTRIES = NUM_ENTRIES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // mode[0], source_id[8:1], service_id[16:9], op_code[24:17], session_epoch[40:25],
  // req_id[72:41], result_stage[80:73], result_status[96:81], now_time[128:97], zeros
  input  wire logic [IN_W-1:0]  in_tdata,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // outcome[1:0], hit_stage[9:2], hit_status[25:10], slot_used[31:26]
  output logic      [OUT_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  input  wire logic             cfg_wr_en,
  input  wire logic [31:0]      cfg_wr_data
);

  localparam int unsigned AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // ttl register
  logic [TIME_W-1:0] ttl_r;

  // latched request
  logic              mode_r;
  logic [KEY_W-1:0]  key_r;
  logic [7:0]        svc_r;
  logic [7:0]        opc_r;
  logic [7:0]        stage_r;
  logic [15:0]       status_r;
  logic [TIME_W-1:0] now_r;

  // scan control: idx issues reads, ev marks read data ready for entry ev_idx
  logic [AW:0]       idx_r, idx_nxt;
  logic              ev_r, ev_nxt;
  logic [AW-1:0]     ev_idx_r, ev_idx_nxt;
  logic [AW-1:0]     tgt_r, tgt_nxt;
  logic [TIME_W-1:0] tgt_touch_r, tgt_touch_nxt;

  // finished result waiting for the output register
  outcome_t          res_outcome_r, res_outcome_nxt;
  logic [7:0]        res_stage_r, res_stage_nxt;
  logic [15:0]       res_status_r, res_status_nxt;
  logic [AW-1:0]     res_slot_r, res_slot_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;

  // entry store and compare unit
  logic                   rd_en;
  logic [KEY_W-1:0]       rd_key;
  logic [PAY_W-1:0]       rd_pay;
  logic [TIME_W-1:0]      rd_touch;
  rrc_wr_t                wr_ctl;
  logic [AW-1:0]          wr_addr;
  logic [NUM_ENTRIES-1:0] valid_vec;
  rrc_cmp_t               cmp;

  // per-entry decision terms
  logic ent_valid;
  logic ent_stale;
  logic ent_last;
  logic take_cand;
  logic accept_in;

  assign accept_in = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign rd_en     = (state_r == ST_SCAN) && (idx_r < (AW+1)'(NUM_ENTRIES));

  rrc_mem #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .AW          (AW)
  ) u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (rd_en),
    .rd_addr   (idx_r[AW-1:0]),
    .rd_key    (rd_key),
    .rd_pay    (rd_pay),
    .rd_touch  (rd_touch),
    .wr_ctl    (wr_ctl),
    .wr_addr   (wr_addr),
    .wr_key    (key_r),
    .wr_pay    ({svc_r, opc_r, stage_r, status_r}),
    .wr_touch  (now_r),
    .valid_vec (valid_vec)
  );

  rrc_cmp u_cmp (
    .now_time  (now_r),
    .ttl       (ttl_r),
    .ent_touch (rd_touch),
    .tgt_touch (tgt_touch_r),
    .req_key   (key_r),
    .ent_key   (rd_key),
    .req_svc   (svc_r),
    .req_opc   (opc_r),
    .ent_pay   (rd_pay),
    .res       (cmp)
  );

  always_comb begin
    ent_valid = valid_vec[ev_idx_r];
    ent_stale = ent_valid && cmp.age_exp;
    ent_last  = (ev_idx_r == AW'(NUM_ENTRIES - 1));
    // entry zero always seeds the replacement candidate
    take_cand = (ev_idx_r == '0) || cmp.older;
  end

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    ev_nxt          = ev_r;
    ev_idx_nxt      = ev_idx_r;
    tgt_nxt         = tgt_r;
    tgt_touch_nxt   = tgt_touch_r;
    res_outcome_nxt = res_outcome_r;
    res_stage_nxt   = res_stage_r;
    res_status_nxt  = res_status_r;
    res_slot_nxt    = res_slot_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_data_nxt    = out_data_r;
    wr_ctl          = '0;
    wr_addr         = ev_idx_r;

    case (state_r)
      ST_IDLE: begin
        if (accept_in) begin
          idx_nxt   = '0;
          ev_nxt    = 1'b0;
          tgt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // issue the next read
        ev_nxt     = rd_en;
        ev_idx_nxt = idx_r[AW-1:0];
        if (rd_en) begin
          idx_nxt = idx_r + 1'b1;
        end

        if (ev_r) begin
          if (mode_r == MODE_FIND) begin
            if (ent_stale) begin
              wr_ctl.clr_valid = 1'b1;
            end
            if (ent_valid && !ent_stale && cmp.key_eq) begin
              state_nxt = ST_DONE;
              if (!cmp.attr_eq) begin
                res_outcome_nxt = OUT_CONFLICT;
                res_stage_nxt   = '0;
                res_status_nxt  = '0;
                res_slot_nxt    = '0;
              end else begin
                wr_ctl.touch_we = 1'b1;
                res_outcome_nxt = OUT_FOUND;
                res_stage_nxt   = rd_pay[23:16];
                res_status_nxt  = rd_pay[15:0];
                res_slot_nxt    = ev_idx_r;
              end
            end else if (ent_last) begin
              state_nxt       = ST_DONE;
              res_outcome_nxt = OUT_MISS;
              res_stage_nxt   = '0;
              res_status_nxt  = '0;
              res_slot_nxt    = '0;
            end
          end else begin
            if (!ent_valid || ent_stale) begin
              // free or expired entry takes the store
              wr_ctl.ent_we    = 1'b1;
              wr_ctl.touch_we  = 1'b1;
              wr_ctl.set_valid = 1'b1;
              wr_addr          = ev_idx_r;
              state_nxt        = ST_DONE;
              res_outcome_nxt  = OUT_STORED;
              res_stage_nxt    = '0;
              res_status_nxt   = '0;
              res_slot_nxt     = ev_idx_r;
            end else begin
              if (take_cand) begin
                tgt_nxt       = ev_idx_r;
                tgt_touch_nxt = rd_touch;
              end
              if (ent_last) begin
                // replace the least recently touched entry
                wr_ctl.ent_we    = 1'b1;
                wr_ctl.touch_we  = 1'b1;
                wr_ctl.set_valid = 1'b1;
                wr_addr          = take_cand ? ev_idx_r : tgt_r;
                state_nxt        = ST_DONE;
                res_outcome_nxt  = OUT_STORED;
                res_stage_nxt    = '0;
                res_status_nxt   = '0;
                res_slot_nxt     = take_cand ? ev_idx_r : tgt_r;
              end
            end
          end
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {SLOT_W'(res_slot_r), res_status_r, res_stage_r, res_outcome_r};
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ttl_r       <= TIME_W'(TTL_RESET);
      idx_r       <= '0;
      ev_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      ev_r        <= ev_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        ttl_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept_in) begin
      mode_r   <= in_tdata[0];
      key_r    <= {in_tdata[8:1], in_tdata[40:25], in_tdata[72:41]};
      svc_r    <= in_tdata[16:9];
      opc_r    <= in_tdata[24:17];
      stage_r  <= in_tdata[80:73];
      status_r <= in_tdata[96:81];
      now_r    <= in_tdata[128:97];
    end
    ev_idx_r      <= ev_idx_nxt;
    tgt_r         <= tgt_nxt;
    tgt_touch_r   <= tgt_touch_nxt;
    res_outcome_r <= res_outcome_nxt;
    res_stage_r   <= res_stage_nxt;
    res_status_r  <= res_status_nxt;
    res_slot_r    <= res_slot_nxt;
    out_data_r    <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (idx_r <= (AW+1)'(NUM_ENTRIES)))
    else $error("scan index ran past the last entry");

  a_slot_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && (res_outcome_r == OUT_FOUND || res_outcome_r == OUT_STORED))
      |-> valid_vec[res_slot_r])
    else $error("reported slot is not valid");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[1:0] == OUT_MISS || out_tdata[1:0] == OUT_CONFLICT))
      |-> (out_tdata[31:2] == '0))
    else $error("miss or conflict carries data");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(out_tdata[31:26]) < NUM_ENTRIES))
    else $error("slot outside the cache");

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && ev_r && ent_last) |=> (state_r == ST_DONE))
    else $error("scan did not finish at the last entry");

endmodule : request_result_cache_ttl_lru
`default_nettype wire

// File: dv/tb_request_result_cache_ttl_lru.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_request_result_cache_ttl_lru
// self-checking bench for the request result cache: a queue-fed driver offers
// find and store words with random gaps, a monitor compares every result word
// with a cache model kept in the bench, and the ttl register is swept through
// its extremes between phases
// ----------------------------------------------------------------------------
module tb_request_result_cache_ttl_lru
  import rrc_pkg::*;
();

  localparam int SLOTS = NUM_ENTRIES_DEF;

  // one request word, fields as the block sees them
  typedef struct {
    logic        mode;
    logic [7:0]  source_id;
    logic [7:0]  service_id;
    logic [7:0]  op_code;
    logic [15:0] session_epoch;
    logic [31:0] req_id;
    logic [7:0]  result_stage;
    logic [15:0] result_status;
    logic [31:0] now_time;
  } cache_req_t;

  // one result word
  typedef struct {
    outcome_t    outcome;
    logic [7:0]  hit_stage;
    logic [15:0] hit_status;
    logic [5:0]  slot_used;
  } cache_resp_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  // mode[0], source_id[8:1], service_id[16:9], op_code[24:17], session_epoch[40:25],
  // req_id[72:41], result_stage[80:73], result_status[96:81], now_time[128:97], zeros
  logic [IN_W-1:0]  in_tdata = '0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  // outcome[1:0], hit_stage[9:2], hit_status[25:10], slot_used[31:26]
  logic [OUT_W-1:0] out_tdata;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [31:0]      cfg_wr_data = '0;

  request_result_cache_ttl_lru #(
    .NUM_ENTRIES (SLOTS)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // cache model state
  logic        slot_valid   [SLOTS];
  logic [55:0] slot_key     [SLOTS];
  logic [7:0]  slot_service [SLOTS];
  logic [7:0]  slot_opcode  [SLOTS];
  logic [7:0]  slot_stage   [SLOTS];
  logic [15:0] slot_status  [SLOTS];
  logic [31:0] slot_touch   [SLOTS];
  logic [31:0] ttl_cur = 32'd1000;

  cache_req_t  queued_reqs[$];      // words waiting for the driver
  cache_resp_t predicted_resps[$];  // results owed by the block, oldest first
  cache_req_t  recent_stores[$];    // keys worth asking for again
  cache_req_t  cur_req;
  cache_resp_t got, want;

  int          reqs_queued = 0;
  int          reqs_taken = 0;
  int          resps_seen = 0;
  int          mismatches = 0;
  logic        in_hs = 1'b0;
  int unsigned src_gap = 0;
  int unsigned sink_hold = 0;
  int unsigned sink_gap;
  logic        long_stall_done = 1'b0;
  int unsigned calm_left = 0;
  logic        calm_src = 1'b0;
  logic        calm_snk = 1'b0;
  logic [31:0] wall_ms;

  // ------------------------------------------------------------------------
  // cache model: updates its own state and returns the result word
  // ------------------------------------------------------------------------
  function automatic cache_resp_t cache_lookup(input cache_req_t r);
    cache_resp_t res;
    logic [55:0] key;
    logic [31:0] age;
    logic [31:0] diff;
    int          target;
    bit          done;
    res.outcome    = OUT_MISS;
    res.hit_stage  = '0;
    res.hit_status = '0;
    res.slot_used  = '0;
    key    = {r.source_id, r.session_epoch, r.req_id};
    done   = 1'b0;
    target = 0;
    if (r.mode == MODE_FIND) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!done) begin
          // expiry only reaches the entries the scan actually visits
          age = r.now_time - slot_touch[i];
          if (slot_valid[i] && age >= ttl_cur) slot_valid[i] = 1'b0;
          if (slot_valid[i] && slot_key[i] == key) begin
            done = 1'b1;
            if (slot_service[i] != r.service_id || slot_opcode[i] != r.op_code) begin
              res.outcome = OUT_CONFLICT;
            end else begin
              slot_touch[i]  = r.now_time;
              res.outcome    = OUT_FOUND;
              res.hit_stage  = slot_stage[i];
              res.hit_status = slot_status[i];
              res.slot_used  = i[5:0];
            end
          end
        end
      end
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!done) begin
          age = r.now_time - slot_touch[i];
          if (!slot_valid[i] || age >= ttl_cur) begin
            target = i;
            done   = 1'b1;
          end else if (i != 0) begin
            // wrap-aware: older when the difference comes out negative
            diff = slot_touch[i] - slot_touch[target];
            if (diff[31]) target = i;
          end
        end
      end
      slot_valid[target]   = 1'b1;
      slot_key[target]     = key;
      slot_service[target] = r.service_id;
      slot_opcode[target]  = r.op_code;
      slot_stage[target]   = r.result_stage;
      slot_status[target]  = r.result_status;
      slot_touch[target]   = r.now_time;
      res.outcome   = OUT_STORED;
      res.slot_used = target[5:0];
    end
    return res;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    else if (roll < 85) return $urandom_range(1, 3);
    else if (roll < 96) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic cache_req_t mk_req(input logic mode, input logic [7:0] src,
                                        input logic [7:0] svc, input logic [7:0] opc,
                                        input logic [15:0] epoch, input logic [31:0] rid,
                                        input logic [7:0] stage, input logic [15:0] status,
                                        input logic [31:0] now);
    cache_req_t r;
    r.mode          = mode;
    r.source_id     = src;
    r.service_id    = svc;
    r.op_code       = opc;
    r.session_epoch = epoch;
    r.req_id        = rid;
    r.result_stage  = stage;
    r.result_status = status;
    r.now_time      = now;
    return r;
  endfunction

  task automatic queue_req(input cache_req_t r);
    queued_reqs.push_back(r);
    reqs_queued++;
  endtask

  // random traffic: mostly stores of fresh keys and finds of recently stored
  // ones, with time advancing in steps scaled to the current ttl
  task automatic gen_random(input int unsigned count);
    cache_req_t  r;
    int unsigned tick, step, roll, pick;
    for (int unsigned k = 0; k < count; k++) begin
      tick = ttl_cur / 5 + 1;
      roll = $urandom_range(0, 99);
      if (roll < 8) step = 0;
      else if (roll < 75) step = $urandom_range(0, tick);
      else if (roll < 95) step = $urandom_range(tick, 3 * tick);
      else step = $urandom;
      wall_ms = wall_ms + step;
      r.now_time      = wall_ms;
      r.result_stage  = 8'($urandom);
      r.result_status = 16'($urandom);
      r.source_id     = 8'($urandom);
      r.session_epoch = 16'($urandom);
      r.req_id        = $urandom;
      r.service_id    = 8'($urandom);
      r.op_code       = 8'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        r.mode = MODE_STORE;
        // some stores repeat a recently stored key, which can leave duplicates behind
        if (recent_stores.size() > 0 && $urandom_range(0, 4) == 0) begin
          pick = $urandom_range(0, recent_stores.size() - 1);
          r.source_id     = recent_stores[pick].source_id;
          r.session_epoch = recent_stores[pick].session_epoch;
          r.req_id        = recent_stores[pick].req_id;
        end
        recent_stores.push_back(r);
        if (recent_stores.size() > 12) void'(recent_stores.pop_front());
      end else begin
        r.mode = MODE_FIND;
        if (recent_stores.size() > 0 && roll < 85) begin
          pick = $urandom_range(0, recent_stores.size() - 1);
          r.source_id     = recent_stores[pick].source_id;
          r.session_epoch = recent_stores[pick].session_epoch;
          r.req_id        = recent_stores[pick].req_id;
          r.service_id    = recent_stores[pick].service_id;
          r.op_code       = recent_stores[pick].op_code;
          // occasionally a mismatching attribute to provoke a conflict
          roll = $urandom_range(0, 9);
          if (roll == 0) r.service_id = 8'(r.service_id + 1 + $urandom_range(0, 254));
          else if (roll == 1) r.op_code = 8'(r.op_code + 1 + $urandom_range(0, 254));
        end
      end
      queue_req(r);
    end
  endtask

  // block is idle once every queued word went in and every result came out
  task automatic wait_idle();
    @(negedge clk);
    while (reqs_taken != reqs_queued || predicted_resps.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic set_ttl(input logic [31:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    ttl_cur      = value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // stretches in which the source, the sink or both run without gaps
  // ------------------------------------------------------------------------
  always @(negedge clk) begin
    if (calm_left == 0) begin
      calm_left <= $urandom_range(40, 200);
      calm_src  <= ($urandom_range(0, 3) == 0);
      calm_snk  <= ($urandom_range(0, 3) == 0);
    end else begin
      calm_left <= calm_left - 1;
    end
  end

  // ------------------------------------------------------------------------
  // driver: next word goes out at the falling edge once the last one was taken
  // ------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      src_gap   <= 0;
    end else if (!in_tvalid || in_hs) begin
      if (src_gap > 0) begin
        in_tvalid <= 1'b0;
        src_gap   <= src_gap - 1;
      end else if (queued_reqs.size() > 0) begin
        cur_req = queued_reqs.pop_front();
        in_tdata <= {7'd0, cur_req.now_time, cur_req.result_status, cur_req.result_stage,
                     cur_req.req_id, cur_req.session_epoch, cur_req.op_code,
                     cur_req.service_id, cur_req.source_id, cur_req.mode};
        in_tvalid <= 1'b1;
        src_gap   <= calm_src ? 0 : pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------------
  // receiver: random back-pressure plus one long hold-off that fills the block
  // ------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (sink_hold > 0) begin
      out_tready <= 1'b0;
      sink_hold  <= sink_hold - 1;
    end else if (!long_stall_done && resps_seen >= 150) begin
      out_tready      <= 1'b0;
      sink_hold       <= 400;
      long_stall_done <= 1'b1;
    end else if (calm_snk) begin
      out_tready <= 1'b1;
    end else begin
      sink_gap = pick_gap();
      out_tready <= (sink_gap == 0);
      sink_hold  <= (sink_gap == 0) ? 0 : sink_gap - 1;
    end
  end

  // ------------------------------------------------------------------------
  // monitor: both handshakes sampled at the rising edge
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      resps_seen <= resps_seen + 1;
      got.outcome    = outcome_t'(out_tdata[1:0]);
      got.hit_stage  = out_tdata[9:2];
      got.hit_status = out_tdata[25:10];
      got.slot_used  = out_tdata[31:26];
      if (predicted_resps.size() == 0) begin
        $error("result word 0x%08h with no request outstanding", out_tdata);
        mismatches++;
      end else begin
        want = predicted_resps.pop_front();
        if (got.outcome !== want.outcome) begin
          $error("outcome mismatch: expected %0d, got %0d", want.outcome, got.outcome);
          mismatches++;
        end
        if (got.hit_stage !== want.hit_stage) begin
          $error("hit_stage mismatch: expected 0x%0h, got 0x%0h",
                 want.hit_stage, got.hit_stage);
          mismatches++;
        end
        if (got.hit_status !== want.hit_status) begin
          $error("hit_status mismatch: expected 0x%0h, got 0x%0h",
                 want.hit_status, got.hit_status);
          mismatches++;
        end
        if (got.slot_used !== want.slot_used) begin
          $error("slot_used mismatch: expected %0d, got %0d", want.slot_used, got.slot_used);
          mismatches++;
        end
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      predicted_resps.push_back(cache_lookup(cur_req));
      reqs_taken <= reqs_taken + 1;
    end
    in_hs <= rst_n && in_tvalid && in_tready;
  end

  // ------------------------------------------------------------------------
  // sequence of phases
  // ------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_valid[i]   = 1'b0;
      slot_key[i]     = '0;
      slot_service[i] = '0;
      slot_opcode[i]  = '0;
      slot_stage[i]   = '0;
      slot_status[i]  = '0;
      slot_touch[i]   = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, ttl at its reset value
    // empty cache, all-zero key
    queue_req(mk_req(MODE_FIND, 8'h00, 8'h00, 8'h00, 16'h0000, 32'h0, 8'h00, 16'h0000, 32'd0));
    // all-ones key and payload, then hit and both conflict flavours
    queue_req(mk_req(MODE_STORE, 8'hff, 8'hff, 8'hff, 16'hffff, 32'hffff_ffff,
                     8'hff, 16'hffff, 32'd100));
    queue_req(mk_req(MODE_FIND, 8'hff, 8'hff, 8'hff, 16'hffff, 32'hffff_ffff,
                     8'h00, 16'h0000, 32'd200));
    queue_req(mk_req(MODE_FIND, 8'hff, 8'h00, 8'hff, 16'hffff, 32'hffff_ffff,
                     8'h00, 16'h0000, 32'd210));
    queue_req(mk_req(MODE_FIND, 8'hff, 8'hff, 8'h00, 16'hffff, 32'hffff_ffff,
                     8'h00, 16'h0000, 32'd220));
    queue_req(mk_req(MODE_STORE, 8'h00, 8'h00, 8'h00, 16'h0000, 32'h0, 8'h00, 16'h0000, 32'd230));
    queue_req(mk_req(MODE_FIND, 8'h00, 8'h00, 8'h00, 16'h0000, 32'h0, 8'hff, 16'hffff, 32'd240));
    // duplicate key: the lower entry must answer
    queue_req(mk_req(MODE_STORE, 8'hff, 8'hff, 8'hff, 16'hffff, 32'hffff_ffff,
                     8'h12, 16'h3456, 32'd250));
    queue_req(mk_req(MODE_FIND, 8'hff, 8'hff, 8'hff, 16'hffff, 32'hffff_ffff,
                     8'h00, 16'h0000, 32'd260));
    // fill the rest, then one more forces a least-recently-touched eviction
    for (int i = 1; i <= 6; i++)
      queue_req(mk_req(MODE_STORE, 8'h01, 8'(8'h20 + i), 8'(8'h40 + i), 16'h0001, 32'(i),
                       8'(8'h80 + i), 16'(16'h1000 + i), 32'd260 + 32'(10 * i)));
    // older entries expire, the hit stops the scan before the later ones
    queue_req(mk_req(MODE_FIND, 8'h01, 8'h23, 8'h43, 16'h0001, 32'd3, 8'h00, 16'h0000, 32'd1265));
    // store lands in the entry just expired
    queue_req(mk_req(MODE_STORE, 8'h01, 8'h27, 8'h47, 16'h0001, 32'd7, 8'h87, 16'h1007, 32'd1266));
    queue_req(mk_req(MODE_FIND, 8'hff, 8'hff, 8'hff, 16'hffff, 32'hffff_ffff,
                     8'h00, 16'h0000, 32'd1267));
    // time wraps between store and find
    queue_req(mk_req(MODE_STORE, 8'h01, 8'h28, 8'h48, 16'h0001, 32'd8,
                     8'h88, 16'h1008, 32'hffff_fff0));
    queue_req(mk_req(MODE_FIND, 8'h01, 8'h28, 8'h48, 16'h0001, 32'd8, 8'h00, 16'h0000, 32'h10));
    queue_req(mk_req(MODE_FIND, 8'h01, 8'h28, 8'h49, 16'h0001, 32'd8, 8'h00, 16'h0000, 32'h20));

    wall_ms = 32'hffff_8000;
    gen_random(300);
    wait_idle();

    // zero ttl: every valid entry is expired on sight
    set_ttl(32'd0);
    queue_req(mk_req(MODE_STORE, 8'h02, 8'h11, 8'h22, 16'h0002, 32'd9, 8'h33, 16'h4444, wall_ms));
    queue_req(mk_req(MODE_FIND, 8'h02, 8'h11, 8'h22, 16'h0002, 32'd9, 8'h00, 16'h0000, wall_ms));
    gen_random(150);
    wait_idle();

    // largest ttl: only an age of all ones expires
    set_ttl(32'hffff_ffff);
    queue_req(mk_req(MODE_STORE, 8'h02, 8'h11, 8'h22, 16'h0002, 32'd10, 8'h33, 16'h4444, wall_ms));
    queue_req(mk_req(MODE_FIND, 8'h02, 8'h11, 8'h22, 16'h0002, 32'd10,
                     8'h00, 16'h0000, wall_ms - 1));
    queue_req(mk_req(MODE_STORE, 8'h02, 8'h11, 8'h22, 16'h0002, 32'd11, 8'h55, 16'h6666, wall_ms));
    queue_req(mk_req(MODE_FIND, 8'h02, 8'h11, 8'h22, 16'h0002, 32'd11,
                     8'h00, 16'h0000, wall_ms - 2));
    gen_random(250);
    wait_idle();

    set_ttl($urandom_range(8, 200));
    gen_random(300);
    wait_idle();

    set_ttl($urandom);
    gen_random(280);
    wait_idle();

    if (mismatches == 0) begin
      $display("request_result_cache_ttl_lru verification clean");
    end else begin
      $display("request_result_cache_ttl_lru verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_500_000;
    $display("request_result_cache_ttl_lru verification failed");
    $finish;
  end

endmodule

// File: request_result_cache_ttl_lru.f
hdl/rrc_pkg.sv
hdl/rrc_mem.sv
hdl/rrc_cmp.sv
hdl/request_result_cache_ttl_lru.sv
dv/tb_request_result_cache_ttl_lru.sv
